@@ sv/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the sequenced fragment receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

   localparam int SEQ_W     = 31;
   localparam int START_W   = 32;
   localparam int LEN_W     = 16;
   localparam int PAYLOAD_W = 14;
   localparam int VERDICT_W = 3;
   localparam int COUNT_W   = 16;
   localparam int OUT_W     = 15;
   localparam int FRAG_W    = 14;
   localparam int MAXMSG_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [VERDICT_W-1:0] VERDICT_DELIVER      = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_REASSEMBLED  = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_STORED       = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_CHECKSUM = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_OUT_OF_ORDER = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_MISSING      = 3'd5;
   localparam logic [VERDICT_W-1:0] VERDICT_ILLEGAL_LEN  = 3'd6;
   localparam logic [VERDICT_W-1:0] VERDICT_TOO_LARGE    = 3'd7;

   localparam logic [CSR_IDX_W-1:0] REG_FULL_FRAG_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_MESSAGE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHECKSUM_ENABLE = 2'd2;

   localparam logic [FRAG_W-1:0]   FULL_FRAG_LEN_RESET = 14'd1300;
   localparam logic [MAXMSG_W-1:0] MAX_MESSAGE_RESET   = 16'd16384;

   typedef struct packed {
      logic [SEQ_W-1:0]          sequence_number;
      logic                      is_fragment;
      logic                      checksum_match;
      logic signed [START_W-1:0] fragment_start;
      logic signed [LEN_W-1:0]   fragment_bytes;
      logic [PAYLOAD_W-1:0]      payload_bytes;
   } sfr_item_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [COUNT_W-1:0]   dropped_count;
      logic [OUT_W-1:0]     write_offset;
      logic [OUT_W-1:0]     write_length;
      logic [OUT_W-1:0]     message_length;
   } sfr_result_type;

   typedef struct packed {
      logic [FRAG_W-1:0]   full_frag_len;
      logic [MAXMSG_W-1:0] max_message;
      logic                checksum_enable;
   } sfr_cfg_type;

endpackage

`default_nettype wire

@@ sv/sfr_csr.sv @@
// ----------------------------------------------------------------------------
// sfr_csr
// Configuration registers: fragment size, message limit, checksum enable.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_csr
   import sfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_write_data,
   output sfr_cfg_type               cfg
);

   logic [FRAG_W-1:0]   full_frag_len_ff;
   logic [MAXMSG_W-1:0] max_message_ff;
   logic                checksum_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_frag_len_ff   <= FULL_FRAG_LEN_RESET;
         max_message_ff     <= MAX_MESSAGE_RESET;
         checksum_enable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_FULL_FRAG_LEN:   full_frag_len_ff   <= csr_write_data[FRAG_W-1:0];
            REG_MAX_MESSAGE:     max_message_ff     <= csr_write_data[MAXMSG_W-1:0];
            REG_CHECKSUM_ENABLE: checksum_enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.full_frag_len   = full_frag_len_ff;
   assign cfg.max_message     = max_message_ff;
   assign cfg.checksum_enable = checksum_enable_ff;

endmodule

`default_nettype wire

@@ sv/sfr_engine.sv @@
// ----------------------------------------------------------------------------
// sfr_engine
// Sequence/reassembly state and the per-request decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_engine
   import sfr_pkg::*;
#(
   parameter int BUF_BYTES = 16384
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire sfr_cfg_type  cfg,
   input  wire sfr_item_type item,
   output sfr_result_type    result
);

   localparam int AW = $clog2(BUF_BYTES + 1);
   localparam int SW = ((AW > OUT_W) ? AW : OUT_W) + 1;
   localparam int CW = (SW > MAXMSG_W) ? SW : MAXMSG_W;

   logic [SEQ_W-1:0]   last_seq_ff,   last_seq_in;
   logic [SEQ_W-1:0]   asm_seq_ff,    asm_seq_in;
   logic [AW-1:0]      asm_bytes_ff,  asm_bytes_in;
   logic [COUNT_W-1:0] gap_ff,        gap_in;

   logic               cs_bad;
   logic               order_bad;
   logic [SEQ_W-1:0]   gap_raw;
   logic [COUNT_W-1:0] gap_sat;
   logic [AW-1:0]      cur_bytes;
   logic               start_bad;
   logic [SW-1:0]      sum_bytes;
   logic               len_bad;
   logic               full_frag;
   logic               too_big;

   always_comb begin
      cs_bad    = cfg.checksum_enable && !item.checksum_match;
      order_bad = item.sequence_number <= last_seq_ff;
      gap_raw   = item.sequence_number - last_seq_ff - SEQ_W'(1);
      gap_sat   = (gap_raw[SEQ_W-1:COUNT_W] != '0) ? '1 : gap_raw[COUNT_W-1:0];
      cur_bytes = (item.sequence_number != asm_seq_ff) ? '0 : asm_bytes_ff;
      start_bad = item.fragment_start[START_W-1] ||
                  (item.fragment_start != START_W'(cur_bytes));
      sum_bytes = SW'(cur_bytes) + SW'(item.fragment_bytes[LEN_W-2:0]);
      len_bad   = item.fragment_bytes[LEN_W-1] ||
                  (item.fragment_bytes[LEN_W-2:0] > OUT_W'(item.payload_bytes)) ||
                  (sum_bytes > SW'(BUF_BYTES));
      full_frag = item.fragment_bytes == LEN_W'(cfg.full_frag_len);
      too_big   = CW'(sum_bytes) > CW'(cfg.max_message);
   end

   always_comb begin
      last_seq_in  = last_seq_ff;
      asm_seq_in   = asm_seq_ff;
      asm_bytes_in = asm_bytes_ff;
      gap_in       = gap_ff;

      result.verdict        = VERDICT_DELIVER;
      result.dropped_count  = gap_sat;
      result.write_offset   = '0;
      result.write_length   = '0;
      result.message_length = '0;

      if (cs_bad) begin
         result.verdict       = VERDICT_BAD_CHECKSUM;
         result.dropped_count = gap_ff;
      end else if (order_bad) begin
         result.verdict       = VERDICT_OUT_OF_ORDER;
         result.dropped_count = gap_ff;
      end else begin
         gap_in = gap_sat;
         if (!item.is_fragment) begin
            last_seq_in = item.sequence_number;
         end else begin
            asm_seq_in   = item.sequence_number;
            asm_bytes_in = cur_bytes;
            if (start_bad) begin
               result.verdict = VERDICT_MISSING;
            end else if (len_bad) begin
               result.verdict = VERDICT_ILLEGAL_LEN;
            end else begin
               result.write_offset = OUT_W'(cur_bytes);
               result.write_length = item.fragment_bytes[LEN_W-2:0];
               if (full_frag) begin
                  result.verdict = VERDICT_STORED;
                  asm_bytes_in   = AW'(sum_bytes);
               end else if (too_big) begin
                  result.verdict = VERDICT_TOO_LARGE;
                  asm_bytes_in   = AW'(sum_bytes);
               end else begin
                  result.verdict        = VERDICT_REASSEMBLED;
                  result.message_length = OUT_W'(sum_bytes);
                  asm_bytes_in          = '0;
                  last_seq_in           = item.sequence_number;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= '0;
         asm_seq_ff   <= '0;
         asm_bytes_ff <= '0;
         gap_ff       <= '0;
      end else if (advance) begin
         last_seq_ff  <= last_seq_in;
         asm_seq_ff   <= asm_seq_in;
         asm_bytes_ff <= asm_bytes_in;
         gap_ff       <= gap_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/sequenced_fragment_receiver.sv @@
// An accepted request is captured in the input register; its result is
// captured in the result register when it advances, raising rsp_valid.
// Throughput: one request per cycle; the input register holds one request
// while the result register waits on rsp_stall, and req_stall is raised.
// Reset: synchronous, active high; clears sequence/assembly state and
// restores full fragment length 1300, max_message 16384, checksum_enable 1.
`default_nettype none

// ----------------------------------------------------------------------------
// sequenced_fragment_receiver
// Checks order and fragment continuity of received datagram headers and
// reports the verdict, dropped count and payload copy window per request.
// ----------------------------------------------------------------------------

module sequenced_fragment_receiver
   import sfr_pkg::*;
#(
   parameter int FRAGMENT_BUFFER_BYTES = 16384
)
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [SEQ_W-1:0]            req_sequence_number,
   input  wire logic                        req_is_fragment,
   input  wire logic                        req_checksum_match,
   input  wire logic signed [START_W-1:0]   req_fragment_start,
   input  wire logic signed [LEN_W-1:0]     req_fragment_bytes,
   input  wire logic [PAYLOAD_W-1:0]        req_payload_bytes,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [VERDICT_W-1:0]             rsp_verdict,
   output logic [COUNT_W-1:0]               rsp_dropped_count,
   output logic [OUT_W-1:0]                 rsp_write_offset,
   output logic [OUT_W-1:0]                 rsp_write_length,
   output logic [OUT_W-1:0]                 rsp_message_length,

   input  wire logic                        csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DAT_W-1:0]        csr_write_data
);

   sfr_cfg_type    cfg;
   sfr_item_type   item_ff,  item_in;
   logic           in_valid_ff, in_valid_in;
   sfr_result_type rsp_ff,   rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sfr_result_type result;
   logic           advance;
   logic           accept;

   sfr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sfr_engine #(
      .BUF_BYTES (FRAGMENT_BUFFER_BYTES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .item    (item_ff),
      .result  (result)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      accept    = req_valid && !req_stall;

      item_in.sequence_number = req_sequence_number;
      item_in.is_fragment     = req_is_fragment;
      item_in.checksum_match  = req_checksum_match;
      item_in.fragment_start  = req_fragment_start;
      item_in.fragment_bytes  = req_fragment_bytes;
      item_in.payload_bytes   = req_payload_bytes;

      in_valid_in  = accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
      rsp_in       = result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_ff.verdict;
   assign rsp_dropped_count  = rsp_ff.dropped_count;
   assign rsp_write_offset   = rsp_ff.write_offset;
   assign rsp_write_length   = rsp_ff.write_length;
   assign rsp_message_length = rsp_ff.message_length;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("request stalled while a stage is free");

   a_reject_copies_nothing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == VERDICT_BAD_CHECKSUM ||
                    rsp_verdict == VERDICT_OUT_OF_ORDER ||
                    rsp_verdict == VERDICT_MISSING ||
                    rsp_verdict == VERDICT_ILLEGAL_LEN ||
                    rsp_verdict == VERDICT_DELIVER)
      |-> (rsp_write_offset == '0 && rsp_write_length == '0))
      else $error("copy window reported for a request that copies nothing");

   a_msg_len_only_reassembled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_REASSEMBLED |-> rsp_message_length == '0)
      else $error("message length reported without reassembly");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request did not reach the result register");
`endif

endmodule

`default_nettype wire
